// ----- sv/mbst_pkg.sv -----
// shared types, constants and tables for the dvb start time decoder
package mbst_pkg;

   localparam int NUM_STAGES = 8;

   // first mjd that the annex c conversion covers
   localparam logic [15:0] MJD_FIRST_VALID = 16'd15079;

   // year step: x1 = 20*mjd - 301564, yp = x1 / 7305
   localparam logic [20:0] YEAR_OFFSET  = 21'd301564;
   localparam logic [12:0] YEAR_DIVISOR = 13'd7305;
   localparam logic [19:0] YEAR_RECIP   = 20'd587948;   // floor(2^32 / 7305)
   localparam logic [10:0] DAYS_PER_4Y  = 11'd1461;
   localparam logic [16:0] MJD_BASE     = 17'd14956;

   // month step: x2 = 10000*rest - 1000, mp = x2 / 306001
   localparam logic [13:0] TENTHOUSAND   = 14'd10000;
   localparam logic [23:0] MONTH_OFFSET  = 24'd1000;
   localparam logic [18:0] MONTH_DIVISOR = 19'd306001;
   localparam logic [13:0] MONTH_RECIP   = 14'd14035;  // floor(2^32 / 306001)

   // floor(m * 30.6001) for m = 0 .. 15
   localparam logic [8:0] MONTH_DAYS_TABLE [16] = '{
      9'd0,   9'd30,  9'd61,  9'd91,  9'd122, 9'd153, 9'd183, 9'd214,
      9'd244, 9'd275, 9'd306, 9'd336, 9'd367, 9'd397, 9'd428, 9'd459
   };

   typedef struct packed {
      logic [15:0] mjd_date;
      logic [23:0] bcd_time;
   } req_type;

   typedef struct packed {
      logic [7:0] year_since_1900;
      logic [3:0] month_number;
      logic [4:0] day_of_month;
      logic [7:0] hours;
      logic [7:0] minutes;
      logic [7:0] seconds;
      logic       date_valid;
   } rsp_type;

   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
   } pipe_ctrl_type;

   typedef struct packed {
      logic [7:0] year_since_1900;
      logic [3:0] month_number;
      logic [4:0] day_of_month;
      logic       date_valid;
   } date_type;

   typedef struct packed {
      logic [7:0] hours;
      logic [7:0] minutes;
      logic [7:0] seconds;
   } time_type;

endpackage

// ----- sv/mbst_pipe_ctrl.sv -----
// valid bits and per-stage load enables of the decoder pipeline
module mbst_pipe_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output mbst_pkg::pipe_ctrl_type ctrl
);

   logic [mbst_pkg::NUM_STAGES-1:0] valid_ff;
   logic [mbst_pkg::NUM_STAGES-1:0] valid_in;
   logic [mbst_pkg::NUM_STAGES:0]   ready;

   // a stage takes new data when it is empty or its contents move on
   always_comb begin
      ready[mbst_pkg::NUM_STAGES] = !rsp_stall;
      for (int k = mbst_pkg::NUM_STAGES - 1; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
   end

   always_comb begin
      if (ready[0]) begin
         valid_in[0] = req_valid;
      end else begin
         valid_in[0] = valid_ff[0];
      end
      for (int k = 1; k < mbst_pkg::NUM_STAGES; k++) begin
         if (ready[k]) begin
            valid_in[k] = valid_ff[k-1];
         end else begin
            valid_in[k] = valid_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctrl.load = ready[mbst_pkg::NUM_STAGES-1:0];
   assign req_stall = !ready[0];
   assign rsp_valid = valid_ff[mbst_pkg::NUM_STAGES-1];

endmodule

// ----- sv/mbst_time_path.sv -----
// bcd to binary conversion of hh mm ss, carried along the pipeline
module mbst_time_path (
   input  logic                    clock,
   input  logic [23:0]             bcd_time,
   input  mbst_pkg::pipe_ctrl_type ctrl,
   output mbst_pkg::time_type      time_out
);

   mbst_pkg::time_type time_ff [mbst_pkg::NUM_STAGES];
   mbst_pkg::time_type time_in;

   function automatic logic [7:0] bcd_pair(input logic [7:0] pair);
      logic [7:0] tens;
      tens = {4'd0, pair[7:4]};
      return (tens << 3) + (tens << 1) + {4'd0, pair[3:0]};
   endfunction

   always_comb begin
      time_in.hours   = bcd_pair(bcd_time[23:16]);
      time_in.minutes = bcd_pair(bcd_time[15:8]);
      time_in.seconds = bcd_pair(bcd_time[7:0]);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         time_ff[0] <= time_in;
      end
      for (int k = 1; k < mbst_pkg::NUM_STAGES; k++) begin
         if (ctrl.load[k]) begin
            time_ff[k] <= time_ff[k-1];
         end
      end
   end

   assign time_out = time_ff[mbst_pkg::NUM_STAGES-1];

endmodule

// ----- sv/mbst_date_path.sv -----
// mjd to year, month and day over eight stages with two reciprocal divides
module mbst_date_path (
   input  logic                    clock,
   input  logic [15:0]             mjd_date,
   input  mbst_pkg::pipe_ctrl_type ctrl,
   output mbst_pkg::date_type      date_out
);

   // stage 0: offset year numerator
   logic [19:0] x1_s0_ff, x1_s0_in;
   logic [15:0] mjd_s0_ff;
   logic        dv_s0_ff, dv_s0_in;
   // stage 1: reciprocal multiply for / 7305
   logic [7:0]  q_s1_ff, q_s1_in;
   logic [19:0] x1_s1_ff;
   logic [15:0] mjd_s1_ff;
   logic        dv_s1_ff;
   // stage 2: quotient correction
   logic [7:0]  yp_s2_ff, yp_s2_in;
   logic [15:0] mjd_s2_ff;
   logic        dv_s2_ff;
   // stage 3: days left in the year
   logic [9:0]  rest_s3_ff, rest_s3_in;
   logic [7:0]  yp_s3_ff;
   logic        dv_s3_ff;
   // stage 4: month numerator
   logic [23:0] x2_s4_ff, x2_s4_in;
   logic [9:0]  rest_s4_ff;
   logic [7:0]  yp_s4_ff;
   logic        dv_s4_ff;
   // stage 5: reciprocal multiply for / 306001
   logic [3:0]  q_s5_ff, q_s5_in;
   logic [23:0] x2_s5_ff;
   logic [9:0]  rest_s5_ff;
   logic [7:0]  yp_s5_ff;
   logic        dv_s5_ff;
   // stage 6: quotient correction
   logic [3:0]  mp_s6_ff, mp_s6_in;
   logic [9:0]  rest_s6_ff;
   logic [7:0]  yp_s6_ff;
   logic        dv_s6_ff;
   // stage 7: final fields
   mbst_pkg::date_type date_s7_ff, date_s7_in;

   logic [20:0] x1_wide;
   logic [39:0] prod_y;
   logic [20:0] qmul_y;
   logic [19:0] rem_y;
   logic [18:0] ydays_prod;
   logic [16:0] ydays;
   logic [16:0] rest_wide;
   logic [23:0] x2_prod;
   logic [37:0] prod_m;
   logic [22:0] qmul_m;
   logic [23:0] rem_m;
   logic [8:0]  mdays;
   logic [9:0]  day_wide;
   logic        wrap;

   always_comb begin
      dv_s0_in = (mjd_date >= mbst_pkg::MJD_FIRST_VALID);
      x1_wide  = ({5'd0, mjd_date} << 4) + ({5'd0, mjd_date} << 2) - mbst_pkg::YEAR_OFFSET;
      x1_s0_in = x1_wide[19:0];
   end

   always_comb begin
      prod_y  = x1_s0_ff * mbst_pkg::YEAR_RECIP;
      q_s1_in = prod_y[39:32];
   end

   // the estimate is never more than one below the true quotient
   always_comb begin
      qmul_y   = q_s1_ff * mbst_pkg::YEAR_DIVISOR;
      rem_y    = x1_s1_ff - qmul_y[19:0];
      yp_s2_in = q_s1_ff + {7'd0, (rem_y >= {7'd0, mbst_pkg::YEAR_DIVISOR})};
   end

   always_comb begin
      ydays_prod = yp_s2_ff * mbst_pkg::DAYS_PER_4Y;
      ydays      = ydays_prod[18:2];
      rest_wide  = {1'b0, mjd_s2_ff} - mbst_pkg::MJD_BASE - ydays;
      rest_s3_in = rest_wide[9:0];
   end

   always_comb begin
      x2_prod  = rest_s3_ff * mbst_pkg::TENTHOUSAND;
      x2_s4_in = x2_prod - mbst_pkg::MONTH_OFFSET;
   end

   always_comb begin
      prod_m  = x2_s4_ff * mbst_pkg::MONTH_RECIP;
      q_s5_in = prod_m[35:32];
   end

   always_comb begin
      qmul_m   = q_s5_ff * mbst_pkg::MONTH_DIVISOR;
      rem_m    = x2_s5_ff - {1'b0, qmul_m};
      mp_s6_in = q_s5_ff + {3'd0, (rem_m >= {5'd0, mbst_pkg::MONTH_DIVISOR})};
   end

   // january and february count as months 14 and 15 of the previous year
   always_comb begin
      mdays    = mbst_pkg::MONTH_DAYS_TABLE[mp_s6_ff];
      day_wide = rest_s6_ff - {1'b0, mdays};
      wrap     = (mp_s6_ff == 4'd14) || (mp_s6_ff == 4'd15);
      date_s7_in.date_valid = dv_s6_ff;
      if (dv_s6_ff) begin
         date_s7_in.year_since_1900 = yp_s6_ff + {7'd0, wrap};
         date_s7_in.month_number    = wrap ? (mp_s6_ff - 4'd13) : (mp_s6_ff - 4'd1);
         date_s7_in.day_of_month    = day_wide[4:0];
      end else begin
         date_s7_in.year_since_1900 = '0;
         date_s7_in.month_number    = '0;
         date_s7_in.day_of_month    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         x1_s0_ff  <= x1_s0_in;
         mjd_s0_ff <= mjd_date;
         dv_s0_ff  <= dv_s0_in;
      end
      if (ctrl.load[1]) begin
         q_s1_ff   <= q_s1_in;
         x1_s1_ff  <= x1_s0_ff;
         mjd_s1_ff <= mjd_s0_ff;
         dv_s1_ff  <= dv_s0_ff;
      end
      if (ctrl.load[2]) begin
         yp_s2_ff  <= yp_s2_in;
         mjd_s2_ff <= mjd_s1_ff;
         dv_s2_ff  <= dv_s1_ff;
      end
      if (ctrl.load[3]) begin
         rest_s3_ff <= rest_s3_in;
         yp_s3_ff   <= yp_s2_ff;
         dv_s3_ff   <= dv_s2_ff;
      end
      if (ctrl.load[4]) begin
         x2_s4_ff   <= x2_s4_in;
         rest_s4_ff <= rest_s3_ff;
         yp_s4_ff   <= yp_s3_ff;
         dv_s4_ff   <= dv_s3_ff;
      end
      if (ctrl.load[5]) begin
         q_s5_ff    <= q_s5_in;
         x2_s5_ff   <= x2_s4_ff;
         rest_s5_ff <= rest_s4_ff;
         yp_s5_ff   <= yp_s4_ff;
         dv_s5_ff   <= dv_s4_ff;
      end
      if (ctrl.load[6]) begin
         mp_s6_ff   <= mp_s6_in;
         rest_s6_ff <= rest_s5_ff;
         yp_s6_ff   <= yp_s5_ff;
         dv_s6_ff   <= dv_s5_ff;
      end
      if (ctrl.load[7]) begin
         date_s7_ff <= date_s7_in;
      end
   end

   assign date_out = date_s7_ff;

endmodule

// ----- sv/mjd_bcd_start_time_decoder.sv -----
// top level of the dvb event start time decoder
// Each request carries one DVB start time (16-bit MJD plus six BCD digits
// hhmmss) and yields exactly one response with year since 1900, month, day,
// the three time fields in binary and a date_valid flag that is low for MJD
// below 15079, in which case the date fields read zero. BCD digits are not
// checked. One request is taken every cycle unless a stalled response backs
// up a full pipeline; the depth comes from the two divisions by constants,
// each done as a reciprocal multiply stage followed by a correction stage. A
// stalled response holds while the stages behind it keep filling any empty slots.
module mjd_bcd_start_time_decoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mbst_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mbst_pkg::rsp_type rsp_payload
);

   mbst_pkg::pipe_ctrl_type ctrl;
   mbst_pkg::date_type      date_out;
   mbst_pkg::time_type      time_out;

   mbst_pipe_ctrl u_pipe_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .ctrl      (ctrl)
   );

   mbst_date_path u_date_path (
      .clock    (clock),
      .mjd_date (req_payload.mjd_date),
      .ctrl     (ctrl),
      .date_out (date_out)
   );

   mbst_time_path u_time_path (
      .clock    (clock),
      .bcd_time (req_payload.bcd_time),
      .ctrl     (ctrl),
      .time_out (time_out)
   );

   always_comb begin
      rsp_payload.year_since_1900 = date_out.year_since_1900;
      rsp_payload.month_number    = date_out.month_number;
      rsp_payload.day_of_month    = date_out.day_of_month;
      rsp_payload.hours           = time_out.hours;
      rsp_payload.minutes         = time_out.minutes;
      rsp_payload.seconds         = time_out.seconds;
      rsp_payload.date_valid      = date_out.date_valid;
   end

endmodule

// ----- sv/mbst_checker.sv -----
// port-level checks for the start time decoder and their bind
module mbst_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input mbst_pkg::req_type req_payload,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input mbst_pkg::rsp_type rsp_payload
);

   logic unused_req;
   assign unused_req = req_valid ^ (^req_payload);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   a_no_backpressure: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("request stalled while response side is free");

   a_early_date_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.date_valid |->
         rsp_payload.year_since_1900 == 8'd0 && rsp_payload.month_number == 4'd0 &&
         rsp_payload.day_of_month == 5'd0)
      else $error("date fields nonzero for early date");

   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.date_valid |->
         rsp_payload.month_number >= 4'd1 && rsp_payload.month_number <= 4'd12 &&
         rsp_payload.day_of_month != 5'd0)
      else $error("month or day out of range");

endmodule

bind mjd_bcd_start_time_decoder mbst_checker u_mbst_checker (.*);
